FILE: sv/sexpr_pkg.sv
// Shared types and character codes for the s-expression completeness scanner.
// No dependencies.
package sexpr_pkg;

    typedef enum logic [4:0] {
        M_NORMAL,
        M_TOKEN,
        M_STR,
        M_STR_ESC,
        M_COMMENT,
        M_HASH,
        M_CHAR_FIRST,
        M_CHAR_NAME,
        M_FS_WS,
        M_FS_COMMENT,
        M_FS_TOKEN,
        M_FS_STR,
        M_FS_STR_ESC,
        M_FS_LIST,
        M_FS_LSTR,
        M_FS_LSTR_ESC,
        M_FS_LCOMMENT
    } scan_mode_t;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

endpackage

FILE: sv/sexpr_step.sv
// Next-state and verdict logic for one character of the scanner.
// Depends on sexpr_pkg.
module sexpr_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic [7:0]                     ch,
    input  logic                           last,
    input  sexpr_pkg::scan_mode_t          mode,
    input  logic signed [COUNT_WIDTH-1:0]  depth,
    input  logic [COUNT_WIDTH-1:0]         owed,
    input  logic [COUNT_WIDTH-1:0]         fl_depth,
    input  logic                           gave_up,
    output sexpr_pkg::scan_mode_t          mode_next,
    output logic signed [COUNT_WIDTH-1:0]  depth_next,
    output logic [COUNT_WIDTH-1:0]         owed_next,
    output logic [COUNT_WIDTH-1:0]         fl_depth_next,
    output logic                           gave_up_next,
    output logic signed [15:0]             verdict_depth,
    output logic                           needs_more
);

    localparam int EW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic signed [COUNT_WIDTH-1:0] DMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] DMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [EW-1:0] VMAX = EW'(32767);
    localparam logic signed [EW-1:0] VMIN = -EW'(32768);

    function automatic logic is_ws(input logic [7:0] c);
        return (c == sexpr_pkg::CH_SPACE) || (c == sexpr_pkg::CH_TAB) ||
               (c == sexpr_pkg::CH_LF) || (c == sexpr_pkg::CH_CR);
    endfunction

    function automatic logic ends_token(input logic [7:0] c);
        return is_ws(c) || (c == sexpr_pkg::CH_LPAREN) || (c == sexpr_pkg::CH_RPAREN) ||
               (c == sexpr_pkg::CH_DQUOTE) || (c == sexpr_pkg::CH_SEMI);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // a completed form at top level settles one owed form
    function automatic logic [COUNT_WIDTH-1:0] pay_one(
        input logic [COUNT_WIDTH-1:0]        o,
        input logic signed [COUNT_WIDTH-1:0] d
    );
        return ((o != '0) && (d == '0)) ? o - 1'b1 : o;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] owe_one(input logic [COUNT_WIDTH-1:0] o);
        return (&o) ? o : o + 1'b1;
    endfunction

    sexpr_pkg::scan_mode_t          m;
    logic signed [COUNT_WIDTH-1:0]  d;
    logic [COUNT_WIDTH-1:0]         o;
    logic [COUNT_WIDTH-1:0]         f;
    logic                           g;
    logic                           to_normal;
    logic                           incomplete;
    logic signed [EW-1:0]           d_ext;
    logic signed [15:0]             v;
    logic [COUNT_WIDTH-1:0]         o_carry;

    always_comb
    begin
        m         = mode;
        d         = depth;
        o         = owed;
        f         = fl_depth;
        g         = gave_up;
        to_normal = 1'b0;

        if (!g)
        begin
            case (m)
                sexpr_pkg::M_NORMAL:
                    to_normal = 1'b1;
                sexpr_pkg::M_TOKEN:
                    to_normal = ends_token(ch);
                sexpr_pkg::M_STR:
                begin
                    if (ch == sexpr_pkg::CH_BSLASH)
                        m = sexpr_pkg::M_STR_ESC;
                    else if (ch == sexpr_pkg::CH_DQUOTE)
                        m = sexpr_pkg::M_NORMAL;
                end
                sexpr_pkg::M_STR_ESC:
                    m = sexpr_pkg::M_STR;
                sexpr_pkg::M_COMMENT:
                begin
                    if (ch == sexpr_pkg::CH_LF)
                        m = sexpr_pkg::M_NORMAL;
                end
                sexpr_pkg::M_HASH:
                begin
                    if (ch == sexpr_pkg::CH_BSLASH)
                    begin
                        o = pay_one(o, d);
                        m = sexpr_pkg::M_CHAR_FIRST;
                    end
                    else if ((ch == sexpr_pkg::CH_PLUS) || (ch == sexpr_pkg::CH_MINUS))
                        m = sexpr_pkg::M_FS_WS;
                    else
                    begin
                        o = pay_one(o, d);
                        if (ends_token(ch))
                            to_normal = 1'b1;
                        else
                            m = sexpr_pkg::M_TOKEN;
                    end
                end
                sexpr_pkg::M_CHAR_FIRST:
                    m = is_letter(ch) ? sexpr_pkg::M_CHAR_NAME : sexpr_pkg::M_NORMAL;
                sexpr_pkg::M_CHAR_NAME:
                    to_normal = !is_letter(ch);
                sexpr_pkg::M_FS_WS:
                begin
                    if (is_ws(ch))
                        m = sexpr_pkg::M_FS_WS;
                    else if (ch == sexpr_pkg::CH_SEMI)
                        m = sexpr_pkg::M_FS_COMMENT;
                    else if (ch == sexpr_pkg::CH_LPAREN)
                    begin
                        f = COUNT_WIDTH'(1);
                        m = sexpr_pkg::M_FS_LIST;
                    end
                    else if (ch == sexpr_pkg::CH_DQUOTE)
                        m = sexpr_pkg::M_FS_STR;
                    else if ((ch == sexpr_pkg::CH_HASH) || (ch == sexpr_pkg::CH_QUOTE))
                        g = 1'b1;
                    else if (ch == sexpr_pkg::CH_RPAREN)
                    begin
                        // empty feature token, then the ')' closes as usual
                        o         = owe_one(o);
                        to_normal = 1'b1;
                    end
                    else
                        m = sexpr_pkg::M_FS_TOKEN;
                end
                sexpr_pkg::M_FS_COMMENT:
                begin
                    if (ch == sexpr_pkg::CH_LF)
                        m = sexpr_pkg::M_FS_WS;
                end
                sexpr_pkg::M_FS_TOKEN:
                begin
                    if (ends_token(ch))
                    begin
                        o         = owe_one(o);
                        to_normal = 1'b1;
                    end
                end
                sexpr_pkg::M_FS_STR:
                begin
                    if (ch == sexpr_pkg::CH_BSLASH)
                        m = sexpr_pkg::M_FS_STR_ESC;
                    else if (ch == sexpr_pkg::CH_DQUOTE)
                    begin
                        o = owe_one(o);
                        m = sexpr_pkg::M_NORMAL;
                    end
                end
                sexpr_pkg::M_FS_STR_ESC:
                    m = sexpr_pkg::M_FS_STR;
                sexpr_pkg::M_FS_LIST:
                begin
                    if (ch == sexpr_pkg::CH_LPAREN)
                        f = owe_one(f);
                    else if (ch == sexpr_pkg::CH_RPAREN)
                    begin
                        if (f != '0)
                            f = f - 1'b1;
                        if (f == '0)
                        begin
                            o = owe_one(o);
                            m = sexpr_pkg::M_NORMAL;
                        end
                    end
                    else if (ch == sexpr_pkg::CH_DQUOTE)
                        m = sexpr_pkg::M_FS_LSTR;
                    else if (ch == sexpr_pkg::CH_SEMI)
                        m = sexpr_pkg::M_FS_LCOMMENT;
                end
                sexpr_pkg::M_FS_LSTR:
                begin
                    if (ch == sexpr_pkg::CH_BSLASH)
                        m = sexpr_pkg::M_FS_LSTR_ESC;
                    else if (ch == sexpr_pkg::CH_DQUOTE)
                        m = sexpr_pkg::M_FS_LIST;
                end
                sexpr_pkg::M_FS_LSTR_ESC:
                    m = sexpr_pkg::M_FS_LSTR;
                sexpr_pkg::M_FS_LCOMMENT:
                begin
                    if (ch == sexpr_pkg::CH_LF)
                        m = sexpr_pkg::M_FS_LIST;
                end
                default:
                    to_normal = 1'b1;
            endcase

            // character handled as in normal mode (possibly after ending a token)
            if (to_normal)
            begin
                m = sexpr_pkg::M_NORMAL;
                if (ch == sexpr_pkg::CH_DQUOTE)
                begin
                    o = pay_one(o, d);
                    m = sexpr_pkg::M_STR;
                end
                else if (ch == sexpr_pkg::CH_SEMI)
                    m = sexpr_pkg::M_COMMENT;
                else if (ch == sexpr_pkg::CH_HASH)
                    m = sexpr_pkg::M_HASH;
                else if (ch == sexpr_pkg::CH_LPAREN)
                begin
                    if (d != DMAX)
                        d = d + 1'b1;
                end
                else if (ch == sexpr_pkg::CH_RPAREN)
                begin
                    if (d != DMIN)
                        d = d - 1'b1;
                    o = pay_one(o, d);
                end
                else if (!is_ws(ch))
                begin
                    o = pay_one(o, d);
                    m = sexpr_pkg::M_TOKEN;
                end
            end
        end

        // owed count carried forward excludes the end-of-text adjustment below
        o_carry = o;

        // verdict on the state left by this character
        incomplete = 1'b0;
        case (m)
            sexpr_pkg::M_HASH:
                o = pay_one(o, d);
            sexpr_pkg::M_FS_TOKEN:
                o = owe_one(o);
            sexpr_pkg::M_FS_WS, sexpr_pkg::M_FS_COMMENT, sexpr_pkg::M_FS_STR,
            sexpr_pkg::M_FS_STR_ESC, sexpr_pkg::M_FS_LIST, sexpr_pkg::M_FS_LSTR,
            sexpr_pkg::M_FS_LSTR_ESC, sexpr_pkg::M_FS_LCOMMENT:
                incomplete = 1'b1;
            default:
                incomplete = 1'b0;
        endcase

        d_ext = EW'(d);
        if (d_ext > VMAX)
            v = 16'sd32767;
        else if (d_ext < VMIN)
            v = -16'sd32768;
        else
            v = d_ext[15:0];

        if (g || incomplete || (o != '0))
            verdict_depth = 16'sd1;
        else
            verdict_depth = v;
        needs_more = (verdict_depth > 16'sd0);

        if (last)
        begin
            mode_next     = sexpr_pkg::M_NORMAL;
            depth_next    = '0;
            owed_next     = '0;
            fl_depth_next = '0;
            gave_up_next  = 1'b0;
        end
        else
        begin
            mode_next     = m;
            depth_next    = d;
            owed_next     = o_carry;
            fl_depth_next = f;
            gave_up_next  = g;
        end
    end

endmodule

FILE: sv/sexpr_completeness_scanner.sv
// Top level of the s-expression completeness scanner: input register,
// scan state, result register. Depends on sexpr_pkg and sexpr_step.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, ch, last         | into block
//  out     | out_valid, out_stall,                | out of block
//          | verdict_depth, needs_more            |
//
// One character per cycle while in_stall is low. An item sits in the input register and
// its step logic updates the scan state as it leaves; a final character loads
// its result into the output register as it leaves. in_stall rises only when
// the input register holds a final character and the result register is full
// and stalled. Asynchronous active-low reset returns the scan to normal mode
// with all counters zero.
module sexpr_completeness_scanner #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         ch,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] verdict_depth,
    output logic               needs_more
);

    logic                           in_vld_reg;
    logic [7:0]                     ch_reg;
    logic                           last_reg;

    sexpr_pkg::scan_mode_t          mode_reg, mode_next;
    logic signed [COUNT_WIDTH-1:0]  depth_reg, depth_next;
    logic [COUNT_WIDTH-1:0]         owed_reg, owed_next;
    logic [COUNT_WIDTH-1:0]         fl_reg, fl_next;
    logic                           gave_up_reg, gave_up_next;

    logic                           out_vld_reg;
    logic signed [15:0]             verdict_reg;
    logic                           needs_more_reg;

    logic signed [15:0]             step_verdict;
    logic                           step_needs_more;
    logic                           consume;
    logic                           in_accept;

    // a non-final item leaves at once; a final one needs room for its result
    assign consume   = in_vld_reg && (!last_reg || !out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !consume;
    assign in_accept = in_valid && !in_stall;

    sexpr_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .ch            (ch_reg),
        .last          (last_reg),
        .mode          (mode_reg),
        .depth         (depth_reg),
        .owed          (owed_reg),
        .fl_depth      (fl_reg),
        .gave_up       (gave_up_reg),
        .mode_next     (mode_next),
        .depth_next    (depth_next),
        .owed_next     (owed_next),
        .fl_depth_next (fl_next),
        .gave_up_next  (gave_up_next),
        .verdict_depth (step_verdict),
        .needs_more    (step_needs_more)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_accept)
            in_vld_reg <= 1'b1;
        else if (consume)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= sexpr_pkg::M_NORMAL;
            depth_reg   <= '0;
            owed_reg    <= '0;
            fl_reg      <= '0;
            gave_up_reg <= 1'b0;
        end
        else if (consume)
        begin
            mode_reg    <= mode_next;
            depth_reg   <= depth_next;
            owed_reg    <= owed_next;
            fl_reg      <= fl_next;
            gave_up_reg <= gave_up_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (consume && last_reg)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (consume && last_reg)
        begin
            verdict_reg    <= step_verdict;
            needs_more_reg <= step_needs_more;
        end
    end

    assign out_valid     = out_vld_reg;
    assign verdict_depth = verdict_reg;
    assign needs_more    = needs_more_reg;

    // the input register only holds back when a final item finds no room
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && last_reg && out_vld_reg && out_stall))
        else $error("input stalled without a blocked final item");

    // giving up happens only while waiting for a feature expression
    a_gave_up_mode: assert property (@(posedge clk) disable iff (!rst_n)
        gave_up_reg |-> (mode_reg == sexpr_pkg::M_FS_WS))
        else $error("gave_up set outside feature whitespace mode");

    // feature list depth is live only inside a feature list
    a_fl_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (fl_reg != '0) |-> ((mode_reg == sexpr_pkg::M_FS_LIST) ||
                            (mode_reg == sexpr_pkg::M_FS_LSTR) ||
                            (mode_reg == sexpr_pkg::M_FS_LSTR_ESC) ||
                            (mode_reg == sexpr_pkg::M_FS_LCOMMENT)))
        else $error("feature list depth nonzero outside a feature list");

    // a final item leaves the scan state at its reset values
    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && last_reg) |=> ((mode_reg == sexpr_pkg::M_NORMAL) &&
                                   (depth_reg == '0) && (owed_reg == '0) &&
                                   !gave_up_reg))
        else $error("scan state not cleared after a final item");

endmodule

FILE: tb/tb_sexpr_completeness_scanner.sv
// Self-checking testbench for sexpr_completeness_scanner: directed texts, random
// Lisp-like texts under random idling, and a long output hold-off.
// Depends on sexpr_pkg and the scanner RTL.
module tb_sexpr_completeness_scanner;

    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
    localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct {
        logic signed [15:0] depth;
        logic               more;
    } verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         ch = 8'h61;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] verdict_depth;
    logic               needs_more;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;

    verdict_t   verdicts_due[$];
    logic [7:0] text_buf[$];

    // predicted scan state
    sexpr_pkg::scan_mode_t sc_mode;
    logic signed [15:0]    sc_depth;
    logic [15:0]           sc_owed;
    logic [15:0]           sc_flist;
    logic                  sc_gave_up;

    sexpr_completeness_scanner #(.COUNT_WIDTH(16)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ch            (ch),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .verdict_depth (verdict_depth),
        .needs_more    (needs_more)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------- prediction ----------------

    function automatic void clear_scan();
        sc_mode = sexpr_pkg::M_NORMAL;
        sc_depth = '0;
        sc_owed = '0;
        sc_flist = '0;
        sc_gave_up = 1'b0;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == sexpr_pkg::CH_SPACE || c == sexpr_pkg::CH_TAB
            || c == sexpr_pkg::CH_LF || c == sexpr_pkg::CH_CR;
    endfunction

    function automatic logic breaks_token(logic [7:0] c);
        return is_blank(c) || c == sexpr_pkg::CH_LPAREN || c == sexpr_pkg::CH_RPAREN
            || c == sexpr_pkg::CH_DQUOTE || c == sexpr_pkg::CH_SEMI;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void pay_owed();
        if (sc_owed != 0 && sc_depth == 0)
            sc_owed = sc_owed - 1'b1;
    endfunction

    function automatic void add_owed();
        if (sc_owed != COUNT_MAX)
            sc_owed = sc_owed + 1'b1;
    endfunction

    function automatic void plain_char(logic [7:0] c);
        if (c == sexpr_pkg::CH_DQUOTE)
        begin
            pay_owed();
            sc_mode = sexpr_pkg::M_STR;
        end
        else if (c == sexpr_pkg::CH_SEMI)
            sc_mode = sexpr_pkg::M_COMMENT;
        else if (c == sexpr_pkg::CH_HASH)
            sc_mode = sexpr_pkg::M_HASH;
        else if (c == sexpr_pkg::CH_LPAREN)
        begin
            if (sc_depth != DEPTH_MAX)
                sc_depth = sc_depth + 16'sd1;
        end
        else if (c == sexpr_pkg::CH_RPAREN)
        begin
            if (sc_depth != DEPTH_MIN)
                sc_depth = sc_depth - 16'sd1;
            pay_owed();
        end
        else if (!is_blank(c))
        begin
            pay_owed();
            sc_mode = sexpr_pkg::M_TOKEN;
        end
    endfunction

    function automatic void rescan_plain(logic [7:0] c);
        sc_mode = sexpr_pkg::M_NORMAL;
        plain_char(c);
    endfunction

    function automatic void scan_step(logic [7:0] c);
        case (sc_mode)
            sexpr_pkg::M_NORMAL: plain_char(c);
            sexpr_pkg::M_TOKEN: if (breaks_token(c)) rescan_plain(c);
            sexpr_pkg::M_STR:
                if (c == sexpr_pkg::CH_BSLASH)
                    sc_mode = sexpr_pkg::M_STR_ESC;
                else if (c == sexpr_pkg::CH_DQUOTE)
                    sc_mode = sexpr_pkg::M_NORMAL;
            sexpr_pkg::M_STR_ESC: sc_mode = sexpr_pkg::M_STR;
            sexpr_pkg::M_COMMENT: if (c == sexpr_pkg::CH_LF) sc_mode = sexpr_pkg::M_NORMAL;
            sexpr_pkg::M_HASH:
                if (c == sexpr_pkg::CH_BSLASH)
                begin
                    pay_owed();
                    sc_mode = sexpr_pkg::M_CHAR_FIRST;
                end
                else if (c == sexpr_pkg::CH_PLUS || c == sexpr_pkg::CH_MINUS)
                    sc_mode = sexpr_pkg::M_FS_WS;
                else
                begin
                    pay_owed();
                    if (breaks_token(c))
                        rescan_plain(c);
                    else
                        sc_mode = sexpr_pkg::M_TOKEN;
                end
            sexpr_pkg::M_CHAR_FIRST:
                sc_mode = is_alpha(c) ? sexpr_pkg::M_CHAR_NAME : sexpr_pkg::M_NORMAL;
            sexpr_pkg::M_CHAR_NAME: if (!is_alpha(c)) rescan_plain(c);
            sexpr_pkg::M_FS_WS:
                if (!is_blank(c))
                begin
                    if (c == sexpr_pkg::CH_SEMI)
                        sc_mode = sexpr_pkg::M_FS_COMMENT;
                    else if (c == sexpr_pkg::CH_LPAREN)
                    begin
                        sc_flist = 16'd1;
                        sc_mode = sexpr_pkg::M_FS_LIST;
                    end
                    else if (c == sexpr_pkg::CH_DQUOTE)
                        sc_mode = sexpr_pkg::M_FS_STR;
                    else if (c == sexpr_pkg::CH_HASH || c == sexpr_pkg::CH_QUOTE)
                        sc_gave_up = 1'b1;
                    else if (c == sexpr_pkg::CH_RPAREN)
                    begin
                        add_owed();
                        rescan_plain(c);
                    end
                    else
                        sc_mode = sexpr_pkg::M_FS_TOKEN;
                end
            sexpr_pkg::M_FS_COMMENT:
                if (c == sexpr_pkg::CH_LF) sc_mode = sexpr_pkg::M_FS_WS;
            sexpr_pkg::M_FS_TOKEN:
                if (breaks_token(c))
                begin
                    add_owed();
                    rescan_plain(c);
                end
            sexpr_pkg::M_FS_STR:
                if (c == sexpr_pkg::CH_BSLASH)
                    sc_mode = sexpr_pkg::M_FS_STR_ESC;
                else if (c == sexpr_pkg::CH_DQUOTE)
                begin
                    add_owed();
                    sc_mode = sexpr_pkg::M_NORMAL;
                end
            sexpr_pkg::M_FS_STR_ESC: sc_mode = sexpr_pkg::M_FS_STR;
            sexpr_pkg::M_FS_LIST:
                if (c == sexpr_pkg::CH_LPAREN)
                begin
                    if (sc_flist != COUNT_MAX)
                        sc_flist = sc_flist + 1'b1;
                end
                else if (c == sexpr_pkg::CH_RPAREN)
                begin
                    if (sc_flist != 0)
                        sc_flist = sc_flist - 1'b1;
                    if (sc_flist == 0)
                    begin
                        add_owed();
                        sc_mode = sexpr_pkg::M_NORMAL;
                    end
                end
                else if (c == sexpr_pkg::CH_DQUOTE)
                    sc_mode = sexpr_pkg::M_FS_LSTR;
                else if (c == sexpr_pkg::CH_SEMI)
                    sc_mode = sexpr_pkg::M_FS_LCOMMENT;
            sexpr_pkg::M_FS_LSTR:
                if (c == sexpr_pkg::CH_BSLASH)
                    sc_mode = sexpr_pkg::M_FS_LSTR_ESC;
                else if (c == sexpr_pkg::CH_DQUOTE)
                    sc_mode = sexpr_pkg::M_FS_LIST;
            sexpr_pkg::M_FS_LSTR_ESC: sc_mode = sexpr_pkg::M_FS_LSTR;
            sexpr_pkg::M_FS_LCOMMENT:
                if (c == sexpr_pkg::CH_LF) sc_mode = sexpr_pkg::M_FS_LIST;
            default: rescan_plain(c);
        endcase
    endfunction

    function automatic logic signed [15:0] closing_verdict();
        if (sc_gave_up)
            return 16'sd1;
        case (sc_mode)
            sexpr_pkg::M_HASH: pay_owed();
            sexpr_pkg::M_FS_TOKEN: add_owed();
            sexpr_pkg::M_FS_WS, sexpr_pkg::M_FS_COMMENT, sexpr_pkg::M_FS_STR,
            sexpr_pkg::M_FS_STR_ESC, sexpr_pkg::M_FS_LIST, sexpr_pkg::M_FS_LSTR,
            sexpr_pkg::M_FS_LSTR_ESC, sexpr_pkg::M_FS_LCOMMENT:
                return 16'sd1;
            default: ;
        endcase
        if (sc_owed != 0)
            return 16'sd1;
        return sc_depth;
    endfunction

    function automatic void scan_predict(logic [7:0] c, logic fin);
        verdict_t v;
        if (!sc_gave_up)
            scan_step(c);
        if (fin)
        begin
            v.depth = closing_verdict();
            v.more = v.depth > 0;
            verdicts_due.push_back(v);
            clear_scan();
        end
    endfunction

    // ---------------- driving ----------------

    task automatic send_char(logic [7:0] c, logic fin);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        last <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        scan_predict(c, fin);
    endtask

    task automatic send_buf();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic send_text(string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_buf();
    endtask

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch("unexpected verdict_depth", verdict_depth, 0);
            else
            begin
                want = verdicts_due.pop_front();
                if (verdict_depth !== want.depth)
                    report_mismatch("verdict_depth", verdict_depth, want.depth);
                if (needs_more !== want.more)
                    report_mismatch("needs_more", needs_more, want.more);
            end
        end
    end

    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ---------------- random text building ----------------

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return sexpr_pkg::CH_SPACE;
            1: return sexpr_pkg::CH_TAB;
            2: return sexpr_pkg::CH_LF;
            default: return sexpr_pkg::CH_CR;
        endcase
    endfunction

    function automatic void put_token();
        text_buf.push_back(pick("abcxyzQ09"));
        repeat ($urandom_range(3))
            text_buf.push_back(pick("abcxyzXYZ0189+-*/:<>=!?&.,|@#'\\"));
    endfunction

    function automatic void put_string();
        text_buf.push_back(sexpr_pkg::CH_DQUOTE);
        repeat ($urandom_range(4))
        begin
            if ($urandom_range(4) == 0)
            begin
                text_buf.push_back(sexpr_pkg::CH_BSLASH);
                text_buf.push_back(8'($urandom_range(1, 255)));
            end
            else
                text_buf.push_back(pick("ab ;()#x+\n"));
        end
        text_buf.push_back(sexpr_pkg::CH_DQUOTE);
    endfunction

    function automatic void put_comment();
        text_buf.push_back(sexpr_pkg::CH_SEMI);
        repeat ($urandom_range(3))
            text_buf.push_back(pick("ab ()\"#"));
        text_buf.push_back(sexpr_pkg::CH_LF);
    endfunction

    function automatic void put_char_literal();
        text_buf.push_back(sexpr_pkg::CH_HASH);
        text_buf.push_back(sexpr_pkg::CH_BSLASH);
        if ($urandom_range(1))
            text_buf.push_back(8'($urandom_range(1, 255)));
        else
            repeat ($urandom_range(1, 5))
                text_buf.push_back(pick("abzAZ"));
    endfunction

    function automatic void put_feature_list();
        int d;
        text_buf.push_back(sexpr_pkg::CH_LPAREN);
        d = 1;
        repeat ($urandom_range(5))
        begin
            case ($urandom_range(6))
                0: put_token();
                1: text_buf.push_back(pick_blank());
                2:
                begin
                    text_buf.push_back(sexpr_pkg::CH_LPAREN);
                    d++;
                end
                3:
                    if (d > 1)
                    begin
                        text_buf.push_back(sexpr_pkg::CH_RPAREN);
                        d--;
                    end
                4: put_string();
                5: put_comment();
                default:
                begin
                    // '#\(' opens a level here
                    text_buf.push_back(sexpr_pkg::CH_HASH);
                    text_buf.push_back(sexpr_pkg::CH_BSLASH);
                    text_buf.push_back(sexpr_pkg::CH_LPAREN);
                    d++;
                end
            endcase
        end
        repeat (d)
            text_buf.push_back(sexpr_pkg::CH_RPAREN);
    endfunction

    function automatic void put_conditional();
        text_buf.push_back(sexpr_pkg::CH_HASH);
        text_buf.push_back($urandom_range(1) ? sexpr_pkg::CH_PLUS : sexpr_pkg::CH_MINUS);
        case ($urandom_range(3))
            0: ;
            1: text_buf.push_back(pick_blank());
            2: put_comment();
            default:
            begin
                text_buf.push_back(pick_blank());
                text_buf.push_back(pick_blank());
            end
        endcase
        case ($urandom_range(11))
            0, 1, 2, 3: put_token();
            4, 5: put_string();
            6, 7, 8: put_feature_list();
            9: text_buf.push_back(sexpr_pkg::CH_HASH);
            10: text_buf.push_back(sexpr_pkg::CH_QUOTE);
            default: text_buf.push_back(sexpr_pkg::CH_RPAREN);
        endcase
        text_buf.push_back(sexpr_pkg::CH_SPACE);
        // the form that the conditional guards
        if ($urandom_range(3) != 0)
            put_token();
    endfunction

    function automatic void build_text();
        int keep;
        text_buf.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 10))
                text_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4: put_token();
                5, 6: text_buf.push_back(pick_blank());
                7, 8: text_buf.push_back(sexpr_pkg::CH_LPAREN);
                9, 10: text_buf.push_back(sexpr_pkg::CH_RPAREN);
                11, 12: put_string();
                13: put_comment();
                14, 15: put_char_literal();
                16, 17: put_conditional();
                18:
                begin
                    text_buf.push_back(sexpr_pkg::CH_HASH);
                    text_buf.push_back(pick("a(\";1 x)"));
                end
                default: text_buf.push_back(8'($urandom_range(1, 255)));
            endcase
            if ($urandom_range(1))
                text_buf.push_back(sexpr_pkg::CH_SPACE);
        end
        // cut some texts short so they end in every mode
        if ($urandom_range(4) == 0 && text_buf.size() > 1)
        begin
            keep = $urandom_range(1, text_buf.size());
            while (text_buf.size() > keep)
                void'(text_buf.pop_back());
        end
    endfunction

    // ---------------- tests ----------------

    task automatic test_feature_conditionals();
        send_text("#+#x");
        send_text("#+ (");
        send_text("#+a");
        send_text("#+)");
    endtask

    task automatic test_hash_and_strings();
        send_text("#");
        send_text("#a)");
        send_text("\"\\");
        send_text("#\\()");
    endtask

    task automatic test_field_extremes();
        send_char(8'hFF, 1'b1);
        send_char(8'h01, 1'b1);
    endtask

    task automatic test_random_texts(int s_pct, int r_pct, int n_items);
        int sent;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items)
        begin
            build_text();
            send_buf();
            sent += text_buf.size();
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        hold_req <= ~hold_req;
        // one-character texts: each gives a verdict, so the block fills quickly
        repeat (40)
            send_char(pick("abc()#\""), 1'b1);
    endtask

    initial
    begin
        clear_scan();
        send_idle_pct = 38;
        recv_idle_pct = 56;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_feature_conditionals();
        test_hash_and_strings();
        test_field_extremes();
        test_random_texts(38, 56, 460);
        test_random_texts(56, 38, 460);
        test_output_backpressure();
        test_random_texts(0, 0, 460);

        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
